@@ rtl/core/pfe_pkg.sv @@
// Shared types and letter codes for the Playfair encryptor core.
// No dependencies; imported by the front, back and top-level modules.
`default_nettype none

package pfe_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_KEY   = 2'd1,
    OP_MSG   = 2'd2,
    OP_END   = 2'd3
  } pfe_op_e;

  typedef struct packed {
    pfe_op_e    op;
    logic [4:0] letter;
  } pfe_word_t;

  localparam int unsigned NumLetters = 26;

  localparam logic [4:0] LetterA    = 5'd0;
  localparam logic [4:0] LetterI    = 5'd8;
  localparam logic [4:0] LetterJ    = 5'd9;
  localparam logic [4:0] LetterQ    = 5'd16;
  localparam logic [4:0] LetterX    = 5'd23;
  localparam logic [4:0] LetterZ    = 5'd25;
  localparam logic [4:0] Alphabet   = 5'd26;
  localparam logic [4:0] SquareSize = 5'd25;
  localparam logic [2:0] SideMax    = 3'd4;

endpackage

`default_nettype wire

@@ rtl/core/playfair_cipher_encryptor_core.sv @@
// Channel  Direction  Handshake                   Fields
// in       input      in_valid_i / in_stall_o     req_type_i, letter_i
// out      output     out_valid_o / out_stall_i   cipher_letter_o, pair_end_o, message_end_o
//
// Start, key letter and unpaired message letter: handled as the sequencer dequeues them.
// A pair: S_RD_A, S_RD_B, S_KEY_A, S_KEY_B and S_CAP, with one read per cycle on the
// position and key RAMs, then S_EMIT1 and S_EMIT2, which wait while the output stalls.
// The first message or end word after a key first sweeps the alphabet, then re-dispatches
// the held word. The input queue takes up to QueueDepth words meanwhile, then stalls.
// Reset clears the queue, flags, used-letter map and output valid; RAMs are not reset.
// Top level of the Playfair encryptor; depends on pfe_pkg, pfe_front, pfe_back.
`default_nettype none

module playfair_cipher_encryptor_core import pfe_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [4:0] letter_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [4:0]      cipher_letter_o,
  output logic            pair_end_o,
  output logic            message_end_o
);

  logic      q_valid;
  pfe_word_t q_word;
  logic      q_pop;

  pfe_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .letter_i   (letter_i),
    .q_valid_o  (q_valid),
    .q_word_o   (q_word),
    .q_pop_i    (q_pop)
  );

  pfe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_word_i        (q_word),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cipher_letter_o (cipher_letter_o),
    .pair_end_o      (pair_end_o),
    .message_end_o   (message_end_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/pfe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the key square and the letter position tables.
`default_nettype none

module pfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/pfe_front.sv @@
// Front end: accepts request words, folds J into I, drops key and message words
// with out-of-range letters and queues the rest for the back end. Depends on pfe_pkg.
`default_nettype none

module pfe_front import pfe_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [4:0] letter_i,
  output logic            q_valid_o,
  output pfe_word_t       q_word_o,
  input  wire logic       q_pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  pfe_word_t       entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  pfe_op_e         op;
  logic            keep;
  logic            push;
  pfe_word_t       word;

  assign op = pfe_op_e'(req_type_i);

  always_comb begin
    keep = 1'b1;
    unique case (op) inside
      OP_KEY, OP_MSG: keep = (letter_i < Alphabet);
      OP_START, OP_END: keep = 1'b1;
      default: keep = 1'b1;
    endcase
  end

  assign word.op     = op;
  assign word.letter = (letter_i == LetterJ) ? LetterI : letter_i;

  assign in_stall_o = (count_q == Full);
  assign push       = in_valid_i && !in_stall_o && keep;

  always_comb begin
    wr_ptr_d = push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = q_pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    case ({push, q_pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= word;
    end
  end

  assign q_valid_o = (count_q != '0);
  assign q_word_o  = entries_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ rtl/core/pfe_back.sv @@
// Back end: sequencer that builds the key square, pairs message letters and
// encrypts each pair into the output register. Depends on pfe_pkg, pfe_ram.
`default_nettype none

module pfe_back import pfe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  pfe_word_t       q_word_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [4:0]      cipher_letter_o,
  output logic            pair_end_o,
  output logic            message_end_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SWEEP, S_RD_A, S_RD_B, S_KEY_A, S_KEY_B, S_CAP, S_EMIT1, S_EMIT2
  } state_e;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  function automatic logic [2:0] wrap_inc(logic [2:0] v);
    return (v == SideMax) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] cipher_addr(pos_t pa, pos_t pb, logic second);
    pos_t       p;
    pos_t       o;
    logic [2:0] r;
    logic [2:0] c;
    p = second ? pb : pa;
    o = second ? pa : pb;
    if (pa.row == pb.row) begin
      r = p.row;
      c = wrap_inc(p.col);
    end else if (pa.col == pb.col) begin
      r = wrap_inc(p.row);
      c = p.col;
    end else begin
      r = p.row;
      c = o.col;
    end
    return {r, 2'b00} + 5'(r) + 5'(c);
  endfunction

  state_e                state_q, state_d;
  logic [NumLetters-1:0] taken_q, taken_d;
  logic [4:0]            fill_q, fill_d;
  logic [2:0]            fill_row_q, fill_row_d;
  logic [2:0]            fill_col_q, fill_col_d;
  logic                  complete_q, complete_d;
  logic                  held_valid_q, held_valid_d;
  logic [4:0]            held_letter_q, held_letter_d;
  logic [4:0]            scan_q, scan_d;
  pfe_word_t             cur_q, cur_d;
  logic [4:0]            a_q, a_d;
  logic [4:0]            b_q, b_d;
  logic                  last_q, last_d;
  pos_t                  pos_a_q, pos_a_d;
  pos_t                  pos_b_q, pos_b_d;
  logic [4:0]            ca_q, ca_d;
  logic [4:0]            cb_q, cb_d;
  logic                  out_valid_q, out_valid_d;
  logic [4:0]            out_letter_q, out_letter_d;
  logic                  out_pair_end_q, out_pair_end_d;
  logic                  out_msg_end_q, out_msg_end_d;

  pfe_word_t  word;
  logic       go;
  logic       out_free;
  logic       place_en;
  logic [4:0] place_letter;
  logic       pos_re;
  logic [4:0] pos_raddr;
  logic [5:0] pos_rdata;
  pos_t       pos_rd;
  logic       key_re;
  logic [4:0] key_raddr;
  logic [4:0] key_rdata;

  assign word     = (state_q == S_IDLE) ? q_word_i : cur_q;
  assign go       = ((state_q == S_IDLE) && q_valid_i) || (state_q == S_EXEC);
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pos_rd   = pos_t'(pos_rdata);

  always_comb begin
    state_d        = state_q;
    taken_d        = taken_q;
    fill_d         = fill_q;
    fill_row_d     = fill_row_q;
    fill_col_d     = fill_col_q;
    complete_d     = complete_q;
    held_valid_d   = held_valid_q;
    held_letter_d  = held_letter_q;
    scan_d         = scan_q;
    cur_d          = cur_q;
    a_d            = a_q;
    b_d            = b_q;
    last_d         = last_q;
    pos_a_d        = pos_a_q;
    pos_b_d        = pos_b_q;
    ca_d           = ca_q;
    cb_d           = cb_q;
    out_valid_d    = out_free ? 1'b0 : out_valid_q;
    out_letter_d   = out_letter_q;
    out_pair_end_d = out_pair_end_q;
    out_msg_end_d  = out_msg_end_q;
    place_en       = 1'b0;
    place_letter   = word.letter;
    pos_re         = 1'b0;
    pos_raddr      = a_q;
    key_re         = 1'b0;
    key_raddr      = cipher_addr(pos_a_q, pos_b_q, 1'b1);

    unique case (state_q) inside
      S_IDLE, S_EXEC: begin
        if (go) begin
          state_d = S_IDLE;
          unique case (word.op) inside
            OP_START: begin
              taken_d      = '0;
              fill_d       = '0;
              fill_row_d   = '0;
              fill_col_d   = '0;
              complete_d   = 1'b0;
              held_valid_d = 1'b0;
            end
            OP_KEY: begin
              if (!complete_q && !taken_q[word.letter] && (fill_q < SquareSize)) begin
                place_en = 1'b1;
              end
            end
            OP_MSG, OP_END: begin
              if (!complete_q) begin
                taken_d[LetterJ] = 1'b1;
                scan_d           = LetterA;
                cur_d            = word;
                state_d          = S_SWEEP;
              end else if (word.op == OP_MSG) begin
                if (!held_valid_q) begin
                  held_letter_d = word.letter;
                  held_valid_d  = 1'b1;
                end else begin
                  a_d     = held_letter_q;
                  last_d  = 1'b0;
                  state_d = S_RD_A;
                  if (held_letter_q == word.letter) begin
                    b_d = (word.letter == LetterX) ? LetterQ : LetterX;
                  end else begin
                    b_d          = word.letter;
                    held_valid_d = 1'b0;
                  end
                end
              end else if (held_valid_q) begin
                a_d          = held_letter_q;
                b_d          = LetterX;
                last_d       = 1'b1;
                held_valid_d = 1'b0;
                state_d      = S_RD_A;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        place_letter = scan_q;
        if (!taken_q[scan_q] && (fill_q < SquareSize)) begin
          place_en = 1'b1;
        end
        if (scan_q == LetterZ) begin
          complete_d = 1'b1;
          state_d    = S_EXEC;
        end else begin
          scan_d = scan_q + 5'd1;
        end
      end
      S_RD_A: begin
        pos_re    = 1'b1;
        pos_raddr = a_q;
        state_d   = S_RD_B;
      end
      S_RD_B: begin
        pos_re    = 1'b1;
        pos_raddr = b_q;
        pos_a_d   = pos_rd;
        state_d   = S_KEY_A;
      end
      S_KEY_A: begin
        pos_b_d   = pos_rd;
        key_re    = 1'b1;
        key_raddr = cipher_addr(pos_a_q, pos_rd, 1'b0);
        state_d   = S_KEY_B;
      end
      S_KEY_B: begin
        key_re    = 1'b1;
        key_raddr = cipher_addr(pos_a_q, pos_b_q, 1'b1);
        ca_d      = key_rdata;
        state_d   = S_CAP;
      end
      S_CAP: begin
        cb_d    = key_rdata;
        state_d = S_EMIT1;
      end
      S_EMIT1: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_letter_d   = ca_q;
          out_pair_end_d = 1'b0;
          out_msg_end_d  = 1'b0;
          state_d        = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_letter_d   = cb_q;
          out_pair_end_d = 1'b1;
          out_msg_end_d  = last_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (place_en) begin
      taken_d[place_letter] = 1'b1;
      fill_d                = fill_q + 5'd1;
      if (fill_col_q == SideMax) begin
        fill_col_d = 3'd0;
        fill_row_d = fill_row_q + 3'd1;
      end else begin
        fill_col_d = fill_col_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      taken_q        <= '0;
      fill_q         <= '0;
      fill_row_q     <= '0;
      fill_col_q     <= '0;
      complete_q     <= 1'b0;
      held_valid_q   <= 1'b0;
      held_letter_q  <= '0;
      scan_q         <= '0;
      cur_q          <= '0;
      a_q            <= '0;
      b_q            <= '0;
      last_q         <= 1'b0;
      pos_a_q        <= '0;
      pos_b_q        <= '0;
      ca_q           <= '0;
      cb_q           <= '0;
      out_valid_q    <= 1'b0;
      out_letter_q   <= '0;
      out_pair_end_q <= 1'b0;
      out_msg_end_q  <= 1'b0;
    end else begin
      state_q        <= state_d;
      taken_q        <= taken_d;
      fill_q         <= fill_d;
      fill_row_q     <= fill_row_d;
      fill_col_q     <= fill_col_d;
      complete_q     <= complete_d;
      held_valid_q   <= held_valid_d;
      held_letter_q  <= held_letter_d;
      scan_q         <= scan_d;
      cur_q          <= cur_d;
      a_q            <= a_d;
      b_q            <= b_d;
      last_q         <= last_d;
      pos_a_q        <= pos_a_d;
      pos_b_q        <= pos_b_d;
      ca_q           <= ca_d;
      cb_q           <= cb_d;
      out_valid_q    <= out_valid_d;
      out_letter_q   <= out_letter_d;
      out_pair_end_q <= out_pair_end_d;
      out_msg_end_q  <= out_msg_end_d;
    end
  end

  pfe_ram #(
    .Width (5),
    .Depth (25)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (place_en),
    .waddr_i (fill_q),
    .wdata_i (place_letter),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  pfe_ram #(
    .Width (6),
    .Depth (26)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (place_en),
    .waddr_i (place_letter),
    .wdata_i ({fill_row_q, fill_col_q}),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign cipher_letter_o = out_letter_q;
  assign pair_end_o      = out_pair_end_q;
  assign message_end_o   = out_msg_end_q;

  a_complete_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_q |-> (fill_q == SquareSize))
    else $error("square marked complete without 25 letters");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= SquareSize)
    else $error("fill count past square size");

  a_pair_needs_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_A) |-> complete_q)
    else $error("pair lookup before square complete");

  a_sweep_incomplete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> !complete_q)
    else $error("sweep running on a complete square");

  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT2) |-> ($past(state_q) == S_EMIT1 || $past(state_q) == S_EMIT2))
    else $error("second pair word without first");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for playfair_cipher_encryptor_core: directed key and message
// sessions, then random sessions under four idle/stall mixes, checked word by word.
// Depends on pfe_pkg and the core RTL; holds its own Playfair predictor.
`timescale 1ns / 1ps

module testbench;
  import pfe_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 100;
  localparam int ShownErrors   = 10;

  typedef struct packed {
    logic [4:0] letter;
    logic       pair_end;
    logic       message_end;
  } cipher_word_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [1:0] req_type_i  = OP_START;
  logic [4:0] letter_i    = LetterA;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [4:0] cipher_letter_o;
  logic       pair_end_o;
  logic       message_end_o;

  playfair_cipher_encryptor_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .letter_i       (letter_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cipher_letter_o(cipher_letter_o),
    .pair_end_o     (pair_end_o),
    .message_end_o  (message_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [4:0] key_tab [25];
  logic [2:0] row_of  [26];
  logic [2:0] col_of  [26];
  bit         used    [26];
  int         fill_n    = 0;
  bit         tab_done  = 1'b0;
  bit         held_v    = 1'b0;
  logic [4:0] held_l    = LetterA;

  cipher_word_t cipher_q [$];
  cipher_word_t want_word;
  cipher_word_t got_word;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned n_errors      = 0;
  int unsigned n_words_in    = 0;
  int unsigned n_words_out   = 0;
  int unsigned n_row_pairs   = 0;
  int unsigned n_col_pairs   = 0;
  int unsigned n_rect_pairs  = 0;
  int unsigned n_fillers     = 0;
  int unsigned n_pads        = 0;

  initial begin
    for (int c = 0; c < NumLetters; c++) used[c] = 1'b0;
  end

  function automatic void flag_error(string msg);
    n_errors++;
    if (n_errors <= ShownErrors) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic void place_letter(logic [4:0] c);
    if (fill_n < SquareSize && c < Alphabet) begin
      used[c]         = 1'b1;
      key_tab[fill_n] = c;
      row_of[c]       = 3'(fill_n / 5);
      col_of[c]       = 3'(fill_n % 5);
      fill_n++;
    end
  endfunction

  function automatic void finish_table();
    if (!tab_done) begin
      used[LetterJ] = 1'b1;
      for (int c = 0; c < NumLetters; c++) begin
        if (!used[c]) place_letter(c[4:0]);
      end
      tab_done = 1'b1;
    end
  endfunction

  function automatic void encrypt_pair(logic [4:0] a, logic [4:0] b, bit last);
    int ar, ac, br, bc;
    cipher_word_t w0, w1;
    ar = int'(row_of[a]);
    ac = int'(col_of[a]);
    br = int'(row_of[b]);
    bc = int'(col_of[b]);
    if (ar == br) begin
      w0.letter = key_tab[ar * 5 + (ac + 1) % 5];
      w1.letter = key_tab[br * 5 + (bc + 1) % 5];
      n_row_pairs++;
    end else if (ac == bc) begin
      w0.letter = key_tab[((ar + 1) % 5) * 5 + ac];
      w1.letter = key_tab[((br + 1) % 5) * 5 + bc];
      n_col_pairs++;
    end else begin
      w0.letter = key_tab[ar * 5 + bc];
      w1.letter = key_tab[br * 5 + ac];
      n_rect_pairs++;
    end
    w0.pair_end    = 1'b0;
    w0.message_end = 1'b0;
    w1.pair_end    = 1'b1;
    w1.message_end = last;
    cipher_q.push_back(w0);
    cipher_q.push_back(w1);
  endfunction

  function automatic void predict_cipher(pfe_op_e op, logic [4:0] ltr);
    logic [4:0] c;
    c = (ltr == LetterJ) ? LetterI : ltr;
    case (op)
      OP_START: begin
        for (int i = 0; i < NumLetters; i++) used[i] = 1'b0;
        fill_n   = 0;
        tab_done = 1'b0;
        held_v   = 1'b0;
      end
      OP_KEY: begin
        if (c < Alphabet && !tab_done) begin
          if (!used[c]) place_letter(c);
        end
      end
      OP_MSG: begin
        if (c < Alphabet) begin
          finish_table();
          if (!held_v) begin
            held_l = c;
            held_v = 1'b1;
          end else if (held_l == c) begin
            n_fillers++;
            encrypt_pair(c, (c == LetterX) ? LetterQ : LetterX, 1'b0);
          end else begin
            held_v = 1'b0;
            encrypt_pair(held_l, c, 1'b0);
          end
        end
      end
      default: begin
        finish_table();
        if (held_v) begin
          held_v = 1'b0;
          n_pads++;
          encrypt_pair(held_l, LetterX, 1'b1);
        end
      end
    endcase
  endfunction

  // Hold valid across back-to-back words; drop it only while idling.
  task automatic send_word(pfe_op_e op, logic [4:0] ltr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= op;
    letter_i   <= ltr;
    do @(posedge clk_i); while (in_stall_o);
    n_words_in++;
    predict_cipher(op, ltr);
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (cipher_q.size() != 0);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  task automatic test_plain_square();
    send_word(OP_MSG, LetterA);
    send_word(OP_MSG, LetterZ);
    send_word(OP_MSG, LetterJ);
    send_word(OP_MSG, LetterI);
    send_word(OP_MSG, LetterX);
    send_word(OP_END, 5'd31);
    wait_results();
  endtask

  task automatic test_key_rules();
    send_word(OP_START, LetterZ);
    send_word(OP_KEY, 5'd31);
    send_word(OP_KEY, 5'd15);
    send_word(OP_KEY, 5'd11);
    send_word(OP_KEY, LetterJ);
    send_word(OP_KEY, LetterA);
    send_word(OP_KEY, LetterA);
    send_word(OP_MSG, LetterX);
    send_word(OP_MSG, LetterX);
    send_word(OP_MSG, 5'd26);
    send_word(OP_KEY, 5'd1);
    send_word(OP_MSG, 5'd15);
    send_word(OP_END, LetterA);
    send_word(OP_MSG, LetterX);
    send_word(OP_END, LetterX);
    send_word(OP_START, LetterA);
    send_word(OP_END, LetterZ);
    wait_results();
  endtask

  task automatic test_random_sessions(int unsigned n_words);
    int unsigned target;
    int          key_len, msg_len;
    logic [4:0]  ltr, prev;
    pfe_op_e     op;
    int unsigned pick;
    target = n_words_in + n_words;
    while (n_words_in < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          op  = pfe_op_e'($urandom_range(3));
          ltr = 5'($urandom_range(31));
          send_word(op, ltr);
        end
      end else begin
        ltr = 5'($urandom_range(31));
        send_word(OP_START, ltr);
        key_len = ($urandom_range(7) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 12);
        repeat (key_len) begin
          ltr = ($urandom_range(15) == 0) ? 5'($urandom_range(26, 31))
                                          : 5'($urandom_range(25));
          send_word(OP_KEY, ltr);
        end
        msg_len = $urandom_range(0, 16);
        prev    = 5'($urandom_range(25));
        repeat (msg_len) begin
          pick = $urandom_range(99);
          if (pick < 20) ltr = prev;
          else if (pick < 28) ltr = LetterX;
          else if (pick < 32) ltr = 5'($urandom_range(26, 31));
          else ltr = 5'($urandom_range(25));
          send_word(OP_MSG, ltr);
          if (ltr < Alphabet) prev = ltr;
        end
        if ($urandom_range(7) != 0) begin
          ltr = 5'($urandom_range(31));
          send_word(OP_END, ltr);
        end
        if ($urandom_range(19) == 0) wait_results();
      end
    end
    wait_results();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_word = '{cipher_letter_o, pair_end_o, message_end_o};
      if (cipher_q.size() == 0) begin
        flag_error($sformatf("unexpected word letter=%0d pair_end=%0b message_end=%0b",
                             cipher_letter_o, pair_end_o, message_end_o));
      end else begin
        want_word = cipher_q.pop_front();
        n_words_out++;
        if (got_word != want_word) begin
          flag_error($sformatf({"expected letter=%0d pair_end=%0b message_end=%0b, ",
                                "got letter=%0d pair_end=%0b message_end=%0b"},
                               want_word.letter, want_word.pair_end, want_word.message_end,
                               got_word.letter, got_word.pair_end, got_word.message_end));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d words pending",
               idle_cycles, cipher_q.size());
      $display("playfair_cipher_encryptor_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_square();
    test_key_rules();
    set_idling(0, 0);
    test_random_sessions(420);
    set_idling(68, 0);
    test_random_sessions(420);
    set_idling(0, 68);
    test_random_sessions(420);
    set_idling(7, 7);
    test_random_sessions(420);
    wait_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("sent %0d words, checked %0d cipher words, %0d mismatches",
             n_words_in, n_words_out, n_errors);
    $display("pairs: %0d same row, %0d same column, %0d rectangle; %0d fillers, %0d pads",
             n_row_pairs, n_col_pairs, n_rect_pairs, n_fillers, n_pads);
    if (n_errors == 0 && cipher_q.size() == 0) begin
      $display("playfair_cipher_encryptor_core test passed");
    end else begin
      $display("playfair_cipher_encryptor_core test failed");
    end
    $finish;
  end

endmodule
